[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is checked only while reset is released.
`define ASSERT_RST(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Assertion that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, clk) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[design/mpbm_pkg.sv]
// ----------------------------------------------------------------------------
// mpbm_pkg
// Types and fixed constants of the monochrome PBM/BMP stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpbm_pkg;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_SECOND,
    PH_SEP_W,
    PH_COMMENT_W,
    PH_DIG_W,
    PH_SEP_H,
    PH_COMMENT_H,
    PH_DIG_H,
    PH_AFTER_CR,
    PH_PBM_DATA,
    PH_BMP_HDR,
    PH_BMP_DATA,
    PH_ERROR
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_EMPTY        = 4'd1,
    ST_TOO_LARGE    = 4'd2,
    ST_UNSUP_FORMAT = 4'd3,
    ST_MISMATCH     = 4'd4,
    ST_HEADER       = 4'd5,
    ST_DIMS         = 4'd6,
    ST_ENCODING     = 4'd7,
    ST_PALETTE      = 4'd8,
    ST_TRUNCATED    = 4'd9,
    ST_TRAILING     = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    PAL_NONE  = 2'd0,
    PAL_BLACK = 2'd1,
    PAL_WHITE = 2'd2
  } pal_kind_e;

  localparam logic FMT_PBM = 1'b0;
  localparam logic FMT_BMP = 1'b1;

  localparam int unsigned PIX_DATA_START    = 62;
  localparam int unsigned DIB_HDR_LEN       = 40;
  localparam int unsigned BMP_PALETTE_START = 54;

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_M    = 8'h4d;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;

  typedef struct packed {
    logic        is_status;
    logic        last;
    logic        top_down;
    logic        fmt;
    status_e     code;
    logic [7:0]  data;
    logic [13:0] addr;
  } res_t;

endpackage

`default_nettype wire

[design/mono_pbm_bmp_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// mono_pbm_bmp_stream_decoder_core
// Parses a PBM P4 or 1-bit BMP file byte by byte and writes bitmap bytes.
// ----------------------------------------------------------------------------
// Input beats carry one file byte in s_axis_tdata, a byte-present flag in
// s_axis_tuser and the end of file in s_axis_tlast. Output beats are either
// a pixel byte write (m_axis_tuser low) or the final status (m_axis_tuser
// high); m_axis_tlast marks the last beat caused by one input beat.
// Each byte is parsed in the cycle it is accepted and its results are
// registered in a four-entry result queue. One input beat is taken per cycle
// while the queue has room for two results; a beat yields at most two
// results and the queue drains one per cycle while m_axis_tready is high.
// s_axis_tready is low while three or more results wait, so a stalled
// receiver stops the input after at most three beats that yield results.
// The user must write the expected format (cfg_we_i/cfg_wdata_i) only while
// idle; the block does not enforce it. Reset clears the parser and the queue
// and selects PBM as expected format; a status beat restarts the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mono_pbm_bmp_stream_decoder_core
  import mpbm_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH      = 400,
  parameter int unsigned IMAGE_HEIGHT     = 300,
  parameter int unsigned BMP_ROW_STRIDE   = 52,
  parameter int unsigned MAX_FILE_BYTES   = 16384,
  parameter int unsigned MAX_HEADER_BYTES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  wire logic        s_axis_tuser,   // [0] byte_present
  input  wire logic        s_axis_tlast,   // end_of_file
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [13:0] pixel_address, [21:14] pixel_data,
                                           // [25:22] status_code, [26] found_format,
                                           // [27] top_down_src, [31:28] zero
  output logic             m_axis_tuser,   // [0] is_status
  output logic             m_axis_tlast    // last_result
);

  localparam int unsigned ROW_BYTES     = (IMAGE_WIDTH + 7) / 8;
  localparam int unsigned BITMAP_BYTES  = ROW_BYTES * IMAGE_HEIGHT;
  localparam int unsigned BMP_IMG_BYTES = BMP_ROW_STRIDE * IMAGE_HEIGHT;
  localparam int unsigned BMP_TOTAL_LEN = PIX_DATA_START + BMP_IMG_BYTES;
  localparam int unsigned BC_TOP0 = (MAX_FILE_BYTES > MAX_HEADER_BYTES) ?
                                    MAX_FILE_BYTES : MAX_HEADER_BYTES;
  localparam int unsigned BC_SAT  = BC_TOP0 + 1;
  localparam int unsigned BC_W    = $clog2(BC_SAT + 1);
  localparam int unsigned DC_TOP  = (BITMAP_BYTES > BMP_IMG_BYTES) ?
                                    BITMAP_BYTES : BMP_IMG_BYTES;
  localparam int unsigned DC_W    = $clog2(DC_TOP + 2);
  localparam int unsigned ROW_W   = $clog2(IMAGE_HEIGHT + 1);
  localparam int unsigned COL_W   = $clog2(BMP_ROW_STRIDE + 1);
  localparam logic [31:0] NEG_HEIGHT = 32'(0) - 32'(IMAGE_HEIGHT);

  function automatic pal_kind_e entry_kind(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
    pal_kind_e k;
    k = PAL_NONE;
    if (d == 8'd0 && a == b && b == c) begin
      if (a == 8'h00) begin
        k = PAL_BLACK;
      end else if (a == 8'hff) begin
        k = PAL_WHITE;
      end
    end
    return k;
  endfunction

  logic             expfmt_q, expfmt_d;
  logic [BC_W-1:0]  bc_q, bc_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       first_q, first_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      width_q, width_d;
  logic             sep_q, sep_d;
  logic             digit_q, digit_d;
  logic [31:0]      shift_q, shift_d;
  logic [7:0]       pal_q [8];
  logic [7:0]       pal_d [8];
  logic [3:0]       eflags_q, eflags_d;
  status_e          ferr_q, ferr_d;
  logic             zw_q, zw_d;
  logic             td_q, td_d;
  logic [ROW_W-1:0] prow_q, prow_d;
  logic [COL_W-1:0] pcol_q, pcol_d;
  logic [DC_W-1:0]  dc_q, dc_d;
  logic             fmt_q, fmt_d;

  res_t             queue_q [4];
  logic [1:0]       wr_q, rd_q;
  logic [2:0]       cnt_q;

  logic             in_acc, out_acc;
  logic             pix_vld, st_vld;
  logic [13:0]      pix_addr;
  logic [7:0]       pix_data;
  status_e          st_code;
  logic             st_ok;
  res_t             res0, res1;
  logic [1:0]       n_push;

  logic [7:0]       b;
  logic             is_sp, is_dig, hdr_over;
  logic [31:0]      dval;
  logic [35:0]      acc10;
  logic [ROW_W-1:0] row_sel;
  logic [13:0]      addr_full;
  pal_kind_e        e0, e1;
  res_t             head;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q <= 3'd2);

  assign b        = s_axis_tdata;
  assign is_sp    = (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  assign is_dig   = (b >= CH_0) && (b <= CH_9);
  assign hdr_over = (32'(bc_q) >= 32'(MAX_HEADER_BYTES));
  assign dval     = 32'(b - CH_0);
  assign acc10    = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 36'(dval);
  assign row_sel  = td_q ? prow_q : ROW_W'(IMAGE_HEIGHT - 1) - prow_q;
  assign addr_full = 14'(32'(row_sel) * 32'(ROW_BYTES) + 32'(pcol_q));

  always_comb begin
    expfmt_d = cfg_we_i ? cfg_wdata_i : expfmt_q;
    bc_d     = bc_q;
    phase_d  = phase_q;
    first_d  = first_q;
    acc_d    = acc_q;
    width_d  = width_q;
    sep_d    = sep_q;
    digit_d  = digit_q;
    shift_d  = shift_q;
    pal_d    = pal_q;
    eflags_d = eflags_q;
    ferr_d   = ferr_q;
    zw_d     = zw_q;
    td_d     = td_q;
    prow_d   = prow_q;
    pcol_d   = pcol_q;
    dc_d     = dc_q;
    fmt_d    = fmt_q;
    pix_vld  = 1'b0;
    pix_addr = '0;
    pix_data = '0;
    st_vld   = 1'b0;
    st_code  = ST_OK;
    st_ok    = 1'b0;
    e0       = PAL_NONE;
    e1       = PAL_NONE;

    if (in_acc && s_axis_tuser) begin
      case (phase_q)
        PH_FIRST: begin
          first_d = b;
          phase_d = PH_SECOND;
        end
        PH_SECOND: begin
          if ((first_q == CH_P && b == CH_4) || (first_q == CH_B && b == CH_M)) begin
            fmt_d = (first_q == CH_B) ? FMT_BMP : FMT_PBM;
            if (fmt_d != expfmt_q) begin
              ferr_d = ST_MISMATCH; phase_d = PH_ERROR;
            end else if (fmt_d == FMT_PBM) begin
              td_d = 1'b1; sep_d = 1'b0; phase_d = PH_SEP_W;
            end else begin
              phase_d = PH_BMP_HDR;
            end
          end else begin
            ferr_d  = (first_q == CH_P) ? ST_ENCODING : ST_UNSUP_FORMAT;
            phase_d = PH_ERROR;
          end
        end
        PH_SEP_W, PH_SEP_H: begin
          if (hdr_over) begin
            ferr_d = ST_HEADER; phase_d = PH_ERROR;
          end else if (is_sp) begin
            sep_d = 1'b1;
          end else if (!sep_q) begin
            ferr_d = ST_HEADER; phase_d = PH_ERROR;
          end else if (b == CH_HASH) begin
            phase_d = (phase_q == PH_SEP_W) ? PH_COMMENT_W : PH_COMMENT_H;
          end else if (is_dig) begin
            phase_d = (phase_q == PH_SEP_W) ? PH_DIG_W : PH_DIG_H;
            acc_d = dval; digit_d = 1'b1;
          end else begin
            ferr_d = ST_HEADER; phase_d = PH_ERROR;
          end
        end
        PH_COMMENT_W, PH_COMMENT_H: begin
          if (hdr_over) begin
            ferr_d = ST_HEADER; phase_d = PH_ERROR;
          end else if (b == CH_CR || b == CH_LF) begin
            phase_d = (phase_q == PH_COMMENT_W) ? PH_SEP_W : PH_SEP_H;
          end
        end
        PH_DIG_W, PH_DIG_H: begin
          if (is_dig) begin
            if (hdr_over || acc10[35:32] != 4'd0) begin
              ferr_d = ST_HEADER; phase_d = PH_ERROR;
            end else begin
              acc_d = acc10[31:0]; digit_d = 1'b1;
            end
          end else if (!digit_q) begin
            ferr_d = ST_HEADER; phase_d = PH_ERROR;
          end else if (phase_q == PH_DIG_W) begin
            width_d = acc_q;
            sep_d   = 1'b0;
            phase_d = PH_SEP_H;
            if (hdr_over || !is_sp) begin
              ferr_d = ST_HEADER; phase_d = PH_ERROR;
            end else begin
              sep_d = 1'b1;
            end
          end else if (width_q != 32'(IMAGE_WIDTH) || acc_q != 32'(IMAGE_HEIGHT)) begin
            ferr_d = ST_DIMS; phase_d = PH_ERROR;
          end else if (hdr_over || !is_sp) begin
            ferr_d = ST_HEADER; phase_d = PH_ERROR;
          end else begin
            phase_d = (b == CH_CR) ? PH_AFTER_CR : PH_PBM_DATA;
          end
        end
        PH_AFTER_CR, PH_PBM_DATA: begin
          phase_d = PH_PBM_DATA;
          if (phase_q == PH_AFTER_CR && b == CH_LF) begin
            if (hdr_over) begin
              ferr_d = ST_HEADER; phase_d = PH_ERROR;
            end
          end else if (32'(dc_q) < 32'(BITMAP_BYTES)) begin
            pix_vld  = 1'b1;
            pix_addr = 14'(dc_q);
            pix_data = ~b;
            dc_d     = dc_q + 1'b1;
          end else begin
            dc_d = DC_W'(BITMAP_BYTES + 1);
          end
        end
        PH_BMP_HDR: begin
          shift_d = {b, shift_q[31:8]};
          for (int i = 0; i < 8; i++) begin
            if (32'(bc_q) == 32'(BMP_PALETTE_START + i)) begin
              pal_d[i] = b;
            end
          end
          case (32'(bc_q))
            32'd5:  if (shift_d != 32'(BMP_TOTAL_LEN)) eflags_d[0] = 1'b1;
            32'd9:  if (shift_d != 32'd0) eflags_d[0] = 1'b1;
            32'd13: if (shift_d != 32'(PIX_DATA_START)) eflags_d[0] = 1'b1;
            32'd17: if (shift_d != 32'(DIB_HDR_LEN)) eflags_d[0] = 1'b1;
            32'd21: if (shift_d != 32'(IMAGE_WIDTH)) eflags_d[1] = 1'b1;
            32'd25: begin
              if (shift_d == NEG_HEIGHT) begin
                td_d = 1'b1;
              end else if (shift_d != 32'(IMAGE_HEIGHT)) begin
                eflags_d[1] = 1'b1;
              end
            end
            32'd27, 32'd29: if (shift_d[31:16] != 16'd1) eflags_d[2] = 1'b1;
            32'd33: if (shift_d != 32'd0) eflags_d[2] = 1'b1;
            32'd37: begin
              if (shift_d != 32'd0 && shift_d != 32'(BMP_IMG_BYTES)) eflags_d[2] = 1'b1;
            end
            32'd49, 32'd53: begin
              if (shift_d != 32'd0 && shift_d != 32'd2) eflags_d[2] = 1'b1;
            end
            default: ;
          endcase
          if (32'(bc_q) == 32'(PIX_DATA_START - 1)) begin
            e0 = entry_kind(pal_d[0], pal_d[1], pal_d[2], pal_d[3]);
            e1 = entry_kind(pal_d[4], pal_d[5], pal_d[6], pal_d[7]);
            if (!((e0 == PAL_BLACK && e1 == PAL_WHITE) ||
                  (e0 == PAL_WHITE && e1 == PAL_BLACK))) begin
              eflags_d[3] = 1'b1;
            end
            phase_d = PH_ERROR;
            if (eflags_d[0]) begin
              ferr_d = ST_HEADER;
            end else if (eflags_d[1]) begin
              ferr_d = ST_DIMS;
            end else if (eflags_d[2]) begin
              ferr_d = ST_ENCODING;
            end else if (eflags_d[3]) begin
              ferr_d = ST_PALETTE;
            end else begin
              zw_d    = (e0 == PAL_WHITE);
              phase_d = PH_BMP_DATA;
            end
          end
        end
        PH_BMP_DATA: begin
          if (32'(dc_q) >= 32'(BMP_IMG_BYTES)) begin
            dc_d = DC_W'(BMP_IMG_BYTES + 1);
          end else begin
            if (32'(pcol_q) < 32'(ROW_BYTES)) begin
              pix_vld  = 1'b1;
              pix_addr = addr_full;
              pix_data = zw_q ? ~b : b;
            end
            if (32'(pcol_q) + 32'd1 >= 32'(BMP_ROW_STRIDE)) begin
              pcol_d = '0;
              prow_d = prow_q + 1'b1;
            end else begin
              pcol_d = pcol_q + 1'b1;
            end
            dc_d = dc_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (32'(bc_q) < 32'(BC_SAT)) begin
        bc_d = bc_q + 1'b1;
      end
    end

    if (in_acc && s_axis_tlast) begin
      st_vld = 1'b1;
      if (bc_d == '0) begin
        st_code = ST_EMPTY;
      end else if (32'(bc_d) > 32'(MAX_FILE_BYTES)) begin
        st_code = ST_TOO_LARGE;
      end else if (ferr_d != ST_OK) begin
        st_code = ferr_d;
      end else begin
        case (phase_d)
          PH_SEP_W, PH_SEP_H: st_code = sep_d ? ST_TRUNCATED : ST_HEADER;
          PH_DIG_W:           st_code = ST_HEADER;
          PH_DIG_H: begin
            st_code = (width_d != 32'(IMAGE_WIDTH) || acc_d != 32'(IMAGE_HEIGHT)) ?
                      ST_DIMS : ST_TRUNCATED;
          end
          PH_PBM_DATA: begin
            st_code = (32'(dc_d) < 32'(BITMAP_BYTES)) ? ST_TRUNCATED :
                      (32'(dc_d) > 32'(BITMAP_BYTES)) ? ST_TRAILING : ST_OK;
          end
          PH_BMP_DATA: begin
            st_code = (32'(dc_d) < 32'(BMP_IMG_BYTES)) ? ST_TRUNCATED :
                      (32'(dc_d) > 32'(BMP_IMG_BYTES)) ? ST_TRAILING : ST_OK;
          end
          default: st_code = ST_TRUNCATED;
        endcase
      end
      st_ok    = (st_code == ST_OK);
      bc_d     = '0;
      phase_d  = PH_FIRST;
      first_d  = '0;
      acc_d    = '0;
      width_d  = '0;
      sep_d    = 1'b0;
      digit_d  = 1'b0;
      shift_d  = '0;
      for (int i = 0; i < 8; i++) begin
        pal_d[i] = '0;
      end
      eflags_d = '0;
      ferr_d   = ST_OK;
      zw_d     = 1'b0;
      prow_d   = '0;
      pcol_d   = '0;
      dc_d     = '0;
    end
  end

  // fmt_d and td_d still hold the decoded values here; the registers clear
  // them after a status beat.
  always_comb begin
    res1           = '0;
    res1.is_status = 1'b1;
    res1.last      = 1'b1;
    res1.code      = st_code;
    res1.fmt       = st_ok ? fmt_d : 1'b0;
    res1.top_down  = st_ok ? td_d : 1'b0;
    res0           = '0;
    res0.last      = !st_vld;
    res0.data      = pix_data;
    res0.addr      = pix_addr;
    if (!pix_vld) begin
      res0 = res1;
    end
    n_push = 2'(pix_vld) + 2'(st_vld);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expfmt_q <= 1'b0;
      bc_q     <= '0;
      phase_q  <= PH_FIRST;
      first_q  <= '0;
      acc_q    <= '0;
      width_q  <= '0;
      sep_q    <= 1'b0;
      digit_q  <= 1'b0;
      shift_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        pal_q[i] <= '0;
      end
      eflags_q <= '0;
      ferr_q   <= ST_OK;
      zw_q     <= 1'b0;
      td_q     <= 1'b0;
      prow_q   <= '0;
      pcol_q   <= '0;
      dc_q     <= '0;
      fmt_q    <= 1'b0;
    end else begin
      expfmt_q <= expfmt_d;
      bc_q     <= bc_d;
      phase_q  <= phase_d;
      first_q  <= first_d;
      acc_q    <= acc_d;
      width_q  <= width_d;
      sep_q    <= sep_d;
      digit_q  <= digit_d;
      shift_q  <= shift_d;
      pal_q    <= pal_d;
      eflags_q <= eflags_d;
      ferr_q   <= ferr_d;
      zw_q     <= zw_d;
      td_q     <= st_vld ? 1'b0 : td_d;
      prow_q   <= prow_d;
      pcol_q   <= pcol_d;
      dc_q     <= dc_d;
      fmt_q    <= st_vld ? 1'b0 : fmt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_q + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + 2'(out_acc);
      cnt_q <= cnt_q + 3'(n_push) - 3'(out_acc);
    end
  end

  assign head          = queue_q[rd_q];
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tuser  = head.is_status;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {4'd0, head.top_down, head.fmt, head.code, head.data, head.addr};

endmodule

`default_nettype wire

[design/mpbm_checker.sv]
// ----------------------------------------------------------------------------
// mpbm_checker
// Port-level checks on the result stream of the stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mpbm_checker
  import mpbm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `ASSERT_RST(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), clk_i, rst_ni)
  `ASSERT_ALWAYS(a_status_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, clk_i)
  `ASSERT_RST(a_code_range, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:22] <= ST_TRAILING && m_axis_tdata[21:0] == 22'd0, clk_i, rst_ni)
  `ASSERT_RST(a_pixel_clean, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:22] == 10'd0, clk_i, rst_ni)

endmodule

bind mono_pbm_bmp_stream_decoder_core mpbm_checker u_mpbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
